// File: hdl/pnmhb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// PNM header parse and BGR convert package
// Shared word types, command format and code constants.
// ---------------------------------------------------------------------------
package pnmhb_pkg;

   localparam logic [2:0] KIND_PIXEL  = 3'd0;
   localparam logic [2:0] KIND_PAD    = 3'd1;
   localparam logic [2:0] KIND_HEADER = 3'd2;
   localparam logic [2:0] KIND_ERROR  = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

   localparam logic [2:0] CAUSE_NONE      = 3'd0;
   localparam logic [2:0] CAUSE_MAGIC     = 3'd1;
   localparam logic [2:0] CAUSE_TOKEN     = 3'd2;
   localparam logic [2:0] CAUSE_COMMENT   = 3'd3;
   localparam logic [2:0] CAUSE_RANGE     = 3'd4;
   localparam logic [2:0] CAUSE_TRUNCATED = 3'd5;

   localparam logic [1:0] CSR_COMMENT_BUDGET = 2'd0;
   localparam logic [1:0] CSR_TOKEN_MAX      = 2'd1;
   localparam logic [1:0] CSR_BITMAP_MODE    = 2'd2;
   localparam logic [1:0] CSR_MAX_DIMENSION  = 2'd3;

   localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       file_end;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  out_kind;
      logic [7:0]  out_byte;
      logic [30:0] image_width;
      logic [30:0] image_height;
      logic [5:0]  bits_per_pixel;
      logic        colour_rgb;
      logic [2:0]  error_cause;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        hdr;
      logic [30:0] width;
      logic [30:0] height;
      logic [5:0]  bpp;
      logic        rgb;
      logic        pix;
      logic [7:0]  b;
      logic [7:0]  g;
      logic [7:0]  r;
      logic [1:0]  pad;
      logic        done;
      logic        err;
      logic [2:0]  cause;
   } cmd_type;

   typedef struct packed {
      logic       hdr;
      logic [1:0] pix;
      logic [1:0] pad;
      logic       done;
      logic       err;
   } work_flags_type;

   typedef enum logic [5:0] {
      PH_P      = 6'b000001,
      PH_DIGIT  = 6'b000010,
      PH_SEP    = 6'b000100,
      PH_TOKEN  = 6'b001000,
      PH_RASTER = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

endpackage
`default_nettype wire

// File: hdl/pnmhb_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// PNM front end
// Parses each input word, holds the parser state and configuration, and
// issues one command per word that produces results.
// ---------------------------------------------------------------------------
module pnmhb_front #(
   parameter int DIM_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_write_data,
   input  wire logic                 accept,
   input  wire pnmhb_pkg::req_word_type in_word,
   output pnmhb_pkg::cmd_type        cmd,
   output logic                      cmd_push
);

   localparam logic [15:0] DIM_MAX = 16'((32'd1 << DIM_BITS) - 32'd1);

   logic [15:0] budget_ff;
   logic [3:0]  tmax_ff;
   logic        mode_ff;
   logic [15:0] maxdim_ff;

   pnmhb_pkg::phase_type phase_ff, phase_in, ph;
   logic        incom_ff, incom_in, incom;
   logic [1:0]  idx_ff, idx_in, idx;
   logic [3:0]  len_ff, len_in, len;
   logic [30:0] vals_ff [3];
   logic [30:0] vals_in [3];
   logic [30:0] vals [3];
   logic [15:0] cl_ff, cl_in;
   logic        rgb_ff, rgb_in, rgb;
   logic        nds_ff, nds_in, nds;
   logic [DIM_BITS-1:0] col_ff, col_in, col, row_ff, row_in, row;
   logic [1:0]  ch_ff, ch_in, ch;
   logic [7:0]  held_ff [2];
   logic        held_we;

   logic [7:0]  c;
   logic        is_ws, is_nl, is_digit;
   logic [30:0] v;
   logic [34:0] sum;
   logic [DIM_BITS-1:0] lim;
   logic [4:0]  bpp_base;
   logic [DIM_BITS:0] col_inc, row_inc;
   pnmhb_pkg::cmd_type cmd_c;

   assign lim = (maxdim_ff > DIM_MAX) ? DIM_MAX[DIM_BITS-1:0] : maxdim_ff[DIM_BITS-1:0];

   always_comb begin
      c        = in_word.data_byte;
      is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      is_nl    = (c == 8'h0A) || (c == 8'h0D);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
      ph    = in_word.file_start ? pnmhb_pkg::PH_P : phase_ff;
      incom = in_word.file_start ? 1'b0 : incom_ff;
      idx   = in_word.file_start ? 2'd0 : idx_ff;
      len   = in_word.file_start ? 4'd0 : len_ff;
      for (int i = 0; i < 3; i++) begin
         vals[i] = in_word.file_start ? 31'd0 : vals_ff[i];
      end
      rgb = in_word.file_start ? 1'b0 : rgb_ff;
      nds = in_word.file_start ? 1'b0 : nds_ff;
      col = in_word.file_start ? '0 : col_ff;
      row = in_word.file_start ? '0 : row_ff;
      ch  = in_word.file_start ? 2'd0 : ch_ff;

      phase_in = ph;
      incom_in = incom;
      idx_in   = idx;
      len_in   = len;
      vals_in  = vals;
      cl_in    = cl_ff;
      rgb_in   = rgb;
      nds_in   = nds;
      col_in   = col;
      row_in   = row;
      ch_in    = ch;
      held_we  = 1'b0;
      cmd_c    = '0;

      v        = vals[idx == 2'd3 ? 2'd2 : idx];
      sum      = {v, 3'b000} + {2'b00, v, 1'b0} + {27'd0, c - 8'h30};
      bpp_base = 5'd16;
      for (int n = 16; n >= 1; n--) begin
         if ({1'b0, vals[2]} <= (32'd1 << n)) begin
            bpp_base = 5'(n);
         end
      end
      col_inc = {1'b0, col} + 1'b1;
      row_inc = {1'b0, row} + 1'b1;

      case (ph)
         pnmhb_pkg::PH_P: begin
            cl_in = budget_ff;
            if (c == 8'h50) begin
               phase_in = pnmhb_pkg::PH_DIGIT;
            end else begin
               cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_MAGIC;
               phase_in = pnmhb_pkg::PH_DONE;
            end
         end
         pnmhb_pkg::PH_DIGIT: begin
            if (c == 8'h35 || c == 8'h36) begin
               rgb_in   = (c == 8'h36);
               phase_in = pnmhb_pkg::PH_SEP;
            end else begin
               cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_MAGIC;
               phase_in = pnmhb_pkg::PH_DONE;
            end
         end
         pnmhb_pkg::PH_SEP: begin
            if (is_ws) begin
               phase_in = pnmhb_pkg::PH_TOKEN;
            end else begin
               cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_MAGIC;
               phase_in = pnmhb_pkg::PH_DONE;
            end
         end
         pnmhb_pkg::PH_TOKEN: begin
            if (incom) begin
               cl_in = cl_ff - 16'd1;
               if (is_nl) begin
                  incom_in = 1'b0;
               end else if (cl_in == 16'd0) begin
                  cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_COMMENT;
                  phase_in = pnmhb_pkg::PH_DONE;
               end
            end else if (c == 8'h23) begin
               if (cl_ff == 16'd0) begin
                  cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_COMMENT;
                  phase_in = pnmhb_pkg::PH_DONE;
               end else begin
                  incom_in = 1'b1;
               end
            end else if (is_ws) begin
               if (len != 4'd0) begin
                  len_in = 4'd0;
                  idx_in = idx + 2'd1;
                  if (idx == 2'd2) begin
                     if (nds) begin
                        cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_TOKEN;
                        phase_in = pnmhb_pkg::PH_DONE;
                     end else if (vals[0] == 31'd0 || vals[1] == 31'd0 ||
                                  vals[2] == 31'd0 || vals[2] > 31'h0000_FFFF) begin
                        cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_RANGE;
                        phase_in = pnmhb_pkg::PH_DONE;
                     end else begin
                        cmd_c.hdr    = 1'b1;
                        cmd_c.width  = vals[0];
                        cmd_c.height = vals[1];
                        cmd_c.rgb    = rgb;
                        cmd_c.bpp    = rgb ? ({1'b0, bpp_base} + {bpp_base, 1'b0})
                                           : {1'b0, bpp_base};
                        if (!mode_ff) begin
                           cmd_c.done = 1'b1;
                           phase_in   = pnmhb_pkg::PH_DONE;
                        end else if (vals[0] > 31'(lim) || vals[1] > 31'(lim) ||
                                     vals[2] != 31'd255) begin
                           cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_RANGE;
                           phase_in = pnmhb_pkg::PH_DONE;
                        end else begin
                           phase_in = pnmhb_pkg::PH_RASTER;
                           col_in   = '0;
                           row_in   = '0;
                           ch_in    = 2'd0;
                        end
                     end
                  end
               end
            end else if (len >= tmax_ff) begin
               cmd_c.err = 1'b1; cmd_c.cause = pnmhb_pkg::CAUSE_TOKEN;
               phase_in = pnmhb_pkg::PH_DONE;
            end else begin
               len_in = len + 4'd1;
               if (is_digit) begin
                  vals_in[idx == 2'd3 ? 2'd2 : idx] =
                     (sum > {4'd0, pnmhb_pkg::SAT31}) ? pnmhb_pkg::SAT31 : sum[30:0];
               end else begin
                  nds_in = 1'b1;
               end
            end
         end
         pnmhb_pkg::PH_RASTER: begin
            if (rgb && ch != 2'd2) begin
               held_we = 1'b1;
               ch_in   = ch + 2'd1;
            end else begin
               cmd_c.pix = 1'b1;
               cmd_c.b   = c;
               cmd_c.g   = rgb ? held_ff[1] : c;
               cmd_c.r   = rgb ? held_ff[0] : c;
               ch_in     = 2'd0;
               col_in    = col_inc[DIM_BITS-1:0];
               if (31'(col_inc) >= vals[0]) begin
                  cmd_c.pad = vals[0][1:0];
                  col_in    = '0;
                  row_in    = row_inc[DIM_BITS-1:0];
                  if (31'(row_inc) >= vals[1]) begin
                     cmd_c.done = 1'b1;
                     phase_in   = pnmhb_pkg::PH_DONE;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (in_word.file_end && phase_in != pnmhb_pkg::PH_DONE) begin
         cmd_c.err   = 1'b1;
         cmd_c.cause = pnmhb_pkg::CAUSE_TRUNCATED;
         phase_in    = pnmhb_pkg::PH_DONE;
      end
   end

   assign cmd      = cmd_c;
   assign cmd_push = accept && (cmd_c.hdr || cmd_c.pix || cmd_c.done || cmd_c.err);

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= 16'd4096;
         tmax_ff   <= 4'd10;
         mode_ff   <= 1'b1;
         maxdim_ff <= 16'hFFFF;
      end else if (csr_write_enable) begin
         case (csr_index)
            pnmhb_pkg::CSR_COMMENT_BUDGET: budget_ff <= csr_write_data;
            pnmhb_pkg::CSR_TOKEN_MAX:      tmax_ff   <= csr_write_data[3:0];
            pnmhb_pkg::CSR_BITMAP_MODE:    mode_ff   <= csr_write_data[0];
            pnmhb_pkg::CSR_MAX_DIMENSION:  maxdim_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pnmhb_pkg::PH_P;
         incom_ff <= 1'b0;
         idx_ff   <= 2'd0;
         len_ff   <= 4'd0;
         for (int i = 0; i < 3; i++) begin
            vals_ff[i] <= 31'd0;
         end
         cl_ff  <= 16'd4096;
         rgb_ff <= 1'b0;
         nds_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         ch_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         incom_ff <= incom_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         vals_ff  <= vals_in;
         cl_ff    <= cl_in;
         rgb_ff   <= rgb_in;
         nds_ff   <= nds_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ch_ff    <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_we) begin
         held_ff[ch[0]] <= c;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pnmhb_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// PNM command queue
// Two-entry queue that decouples the parser from the result emitter.
// ---------------------------------------------------------------------------
module pnmhb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pnmhb_pkg::cmd_type push_cmd,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output pnmhb_pkg::cmd_type      head_cmd
);

   pnmhb_pkg::cmd_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pnmhb_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// PNM result emitter
// Expands each command into result words into a registered output stage,
// one word per cycle while that stage is not stalled by rsp_ready.
// ---------------------------------------------------------------------------
module pnmhb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire pnmhb_pkg::cmd_type   head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pnmhb_pkg::rsp_word_type   rsp_data
);

   pnmhb_pkg::cmd_type       cur_ff, cur_in, src;
   pnmhb_pkg::work_flags_type flags_ff, flags_in, sflags, rem, head_flags;
   pnmhb_pkg::rsp_word_type  word_ff, word;
   logic rsp_valid_ff, rsp_valid_in;
   logic active, out_free, emit, rem_empty;

   always_comb begin
      head_flags.hdr  = head_cmd.hdr;
      head_flags.pix  = head_cmd.pix ? 2'd3 : 2'd0;
      head_flags.pad  = head_cmd.pad;
      head_flags.done = head_cmd.done;
      head_flags.err  = head_cmd.err;

      active   = (flags_ff != '0);
      out_free = !rsp_valid_ff || rsp_ready;
      src      = active ? cur_ff : head_cmd;
      sflags   = active ? flags_ff : head_flags;
      emit     = out_free && (active || head_valid);

      rem  = sflags;
      word = '0;
      if (sflags.hdr) begin
         rem.hdr             = 1'b0;
         word.out_kind       = pnmhb_pkg::KIND_HEADER;
         word.image_width    = src.width;
         word.image_height   = src.height;
         word.bits_per_pixel = src.bpp;
         word.colour_rgb     = src.rgb;
      end else if (sflags.pix != 2'd0) begin
         rem.pix       = sflags.pix - 2'd1;
         word.out_kind = pnmhb_pkg::KIND_PIXEL;
         case (sflags.pix)
            2'd3:    word.out_byte = src.b;
            2'd2:    word.out_byte = src.g;
            default: word.out_byte = src.r;
         endcase
      end else if (sflags.pad != 2'd0) begin
         rem.pad       = sflags.pad - 2'd1;
         word.out_kind = pnmhb_pkg::KIND_PAD;
      end else if (sflags.done) begin
         rem.done      = 1'b0;
         word.out_kind = pnmhb_pkg::KIND_DONE;
      end else begin
         rem.err          = 1'b0;
         word.out_kind    = pnmhb_pkg::KIND_ERROR;
         word.error_cause = src.cause;
      end
      rem_empty = (rem == '0);
      word.last = rem_empty;

      cur_in       = cur_ff;
      flags_in     = flags_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (!active) begin
            pop      = 1'b1;
            cur_in   = head_cmd;
            flags_in = rem;
         end else if (!rem_empty) begin
            flags_in = rem;
         end else if (head_valid) begin
            pop      = 1'b1;
            cur_in   = head_cmd;
            flags_in = head_flags;
         end else begin
            flags_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         word_ff <= word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = word_ff;

endmodule
`default_nettype wire

// File: hdl/pnm_header_parse_bgr_convert_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// PNM header parse and BGR convert unit
// Decodes binary P5/P6 files one byte per word and emits header info,
// BGR pixel bytes with row padding, completion and error words.
// ---------------------------------------------------------------------------
// The parser takes one input word per cycle while the queue has room and
// passes a command for each word that has results into a two-entry queue;
// the emitter drains it at one result word per cycle while rsp_ready is high.
// Header bytes but the last and the first two bytes of a colour pixel give
// no result; a pixel gives its three output bytes, a row end one pad word
// per pad byte; the output port sets the rate. No clearing pass follows reset.
module pnm_header_parse_bgr_convert_unit #(
   parameter int DIM_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [1:0]               csr_index,
   input  wire logic [15:0]              csr_write_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire pnmhb_pkg::req_word_type  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output pnmhb_pkg::rsp_word_type       rsp_data
);

   pnmhb_pkg::cmd_type cmd, head_cmd;
   logic cmd_push, full, head_valid, pop, accept;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   pnmhb_front #(
      .DIM_BITS(DIM_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .in_word          (req_data),
      .cmd              (cmd),
      .cmd_push         (cmd_push)
   );

   pnmhb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pnmhb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
